[rtl/core/pdfcrc_pkg.sv]
// Package for the marker-framed packet deframer with CRC-8 check.
// Holds the transaction types, parser phase and result kind codes, and the CRC byte update.
// No dependencies.
package pdfcrc_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [7:0] MARKER_RESET = 8'd126;
    localparam logic [7:0] POLY_RESET   = 8'h07;

    typedef enum logic [0:0] {
        REG_MARKER = 1'b0,
        REG_POLY   = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HDR1 = 3'd1,
        PH_HDR2 = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       start_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [5:0] frame_length;
        logic [4:0] sequence_res;
        logic [4:0] frame_type;
        logic       crc_ok;
        logic       last;
    } out_item_t;

    // MSB-first CRC-8 update over one byte, unrolled into an XOR network.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ poly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

[rtl/core/pdfcrc_parser.sv]
// Frame parser: marker check, header unpacking, data pass-through and CRC compare.
// Depends on pdfcrc_pkg for the phase codes, transaction types and the CRC update.
module pdfcrc_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_accept,
    input  pdfcrc_pkg::in_item_t  item,
    input  logic [7:0]            marker_value,
    input  logic [7:0]            crc_poly,
    output logic                  res_valid,
    output pdfcrc_pkg::out_item_t res
);

    pdfcrc_pkg::phase_t phase_reg, phase_next;
    logic [5:0] held_length_reg, held_length_next;
    logic [4:0] held_sequence_reg, held_sequence_next;
    logic [4:0] held_type_reg, held_type_next;
    logic [5:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_crc_reg, running_crc_next;
    logic [7:0] crc_upd;
    logic [5:0] bytes_dec;
    logic       marker_bad;

    assign crc_upd    = pdfcrc_pkg::crc8_byte(running_crc_reg, item.rx_byte, crc_poly);
    assign bytes_dec  = bytes_left_reg - 6'd1;
    assign marker_bad = item.rx_byte != marker_value;

    always_comb begin
        phase_next         = phase_reg;
        held_length_next   = held_length_reg;
        held_sequence_next = held_sequence_reg;
        held_type_next     = held_type_reg;
        bytes_left_next    = bytes_left_reg;
        running_crc_next   = running_crc_reg;
        if (item.start_of_frame) begin
            if (marker_bad) begin
                phase_next = pdfcrc_pkg::PH_IDLE;
            end else begin
                phase_next       = pdfcrc_pkg::PH_HDR1;
                running_crc_next = 8'd0;
            end
        end else begin
            unique case (phase_reg)
                pdfcrc_pkg::PH_HDR1: begin
                    held_length_next   = item.rx_byte[7:2];
                    held_sequence_next = {item.rx_byte[1:0], 3'b000};
                    running_crc_next   = crc_upd;
                    phase_next         = pdfcrc_pkg::PH_HDR2;
                end
                pdfcrc_pkg::PH_HDR2: begin
                    held_sequence_next = held_sequence_reg | {2'b00, item.rx_byte[7:5]};
                    held_type_next     = item.rx_byte[4:0];
                    running_crc_next   = crc_upd;
                    bytes_left_next    = held_length_reg;
                    phase_next = (held_length_reg == 6'd0) ? pdfcrc_pkg::PH_CRC
                                                           : pdfcrc_pkg::PH_DATA;
                end
                pdfcrc_pkg::PH_DATA: begin
                    running_crc_next = crc_upd;
                    bytes_left_next  = bytes_dec;
                    if (bytes_dec == 6'd0) begin
                        phase_next = pdfcrc_pkg::PH_CRC;
                    end
                end
                pdfcrc_pkg::PH_CRC: begin
                    phase_next = pdfcrc_pkg::PH_IDLE;
                end
                default: begin
                    phase_next = pdfcrc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        if (item.start_of_frame) begin
            if (marker_bad) begin
                res_valid = 1'b1;
                res.kind  = pdfcrc_pkg::KIND_BAD;
                res.last  = 1'b1;
            end
        end else begin
            unique case (phase_reg)
                pdfcrc_pkg::PH_DATA: begin
                    res_valid     = 1'b1;
                    res.kind      = pdfcrc_pkg::KIND_DATA;
                    res.data_byte = item.rx_byte;
                end
                pdfcrc_pkg::PH_CRC: begin
                    res_valid        = 1'b1;
                    res.kind         = pdfcrc_pkg::KIND_END;
                    res.frame_length = held_length_reg;
                    res.sequence_res = held_sequence_reg;
                    res.frame_type   = held_type_reg;
                    res.crc_ok       = item.rx_byte == running_crc_reg;
                    res.last         = 1'b1;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= pdfcrc_pkg::PH_IDLE;
            held_length_reg   <= '0;
            held_sequence_reg <= '0;
            held_type_reg     <= '0;
            bytes_left_reg    <= '0;
            running_crc_reg   <= '0;
        end else if (item_accept) begin
            phase_reg         <= phase_next;
            held_length_reg   <= held_length_next;
            held_sequence_reg <= held_sequence_next;
            held_type_reg     <= held_type_next;
            bytes_left_reg    <= bytes_left_next;
            running_crc_reg   <= running_crc_next;
        end
    end

endmodule

[rtl/core/packet_deframer_crc8.sv]
// Top level of the marker-framed packet deframer with CRC-8 check.
// Holds the APB register file and the result register; depends on pdfcrc_pkg and pdfcrc_parser.
//
// The block takes one received byte per clock cycle and delivers each result in the cycle after
// its byte is accepted, from a single result register; a new byte is taken whenever that
// register is empty or is being emptied in the same cycle. The rate is set by the CRC-8 byte
// update, an unrolled XOR network between the parser state and the result register. Marker and
// polynomial registers must be written via APB only while the block is idle; not enforced.
module packet_deframer_crc8 (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  pdfcrc_pkg::in_item_t                  s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output pdfcrc_pkg::out_item_t                 m_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pdfcrc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pdfcrc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pdfcrc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    logic [7:0] marker_reg;
    logic [7:0] poly_reg;
    logic       out_valid_reg;
    pdfcrc_pkg::out_item_t out_data_reg;
    logic       s_accept;
    logic       res_valid;
    pdfcrc_pkg::out_item_t res;
    pdfcrc_pkg::reg_index_t reg_sel;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = pdfcrc_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            pdfcrc_pkg::REG_MARKER: prdata = {24'd0, marker_reg};
            pdfcrc_pkg::REG_POLY:   prdata = {24'd0, poly_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= pdfcrc_pkg::MARKER_RESET;
            poly_reg   <= pdfcrc_pkg::POLY_RESET;
        end else if (cfg_write) begin
            if (reg_sel == pdfcrc_pkg::REG_MARKER) begin
                marker_reg <= pwdata[7:0];
            end else begin
                poly_reg <= pwdata[7:0];
            end
        end
    end

    assign s_ready  = !out_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    pdfcrc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_accept  (s_accept),
        .item         (s_data),
        .marker_value (marker_reg),
        .crc_poly     (poly_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_bad_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_data.start_of_frame && (s_data.rx_byte != marker_reg)
        |=> m_valid && (m_data.kind == pdfcrc_pkg::KIND_BAD) && m_data.last)
        else $error("bad start marker did not produce an error result");

    a_good_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_data.start_of_frame && (s_data.rx_byte == marker_reg) |=> !m_valid)
        else $error("valid start marker produced a result");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.kind != pdfcrc_pkg::KIND_DATA)))
        else $error("last flag disagrees with result kind");

    a_header_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind != pdfcrc_pkg::KIND_END)
        |-> (m_data.frame_length == 6'd0) && !m_data.crc_ok)
        else $error("header fields set outside a frame end result");
`endif

endmodule
